// ===== hw/rtl/lidar_packet_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Lidar packet decoder assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef LIDAR_PACKET_DECODER_ASSERT_SVH
`define LIDAR_PACKET_DECODER_ASSERT_SVH

// same-cycle implication, reset-gated
`define LPD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset-gated
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Lidar packet decoder package
// Shared constants, control types and the microcode program.
// ----------------------------------------------------------------------------
package lpd_pkg;

    localparam int PACKET_BYTES = 22;

    localparam logic [7:0] START_BYTE  = 8'hFA;
    localparam logic [7:0] INDEX_FIRST = 8'hA0;
    localparam logic [7:0] INDEX_LAST  = 8'hF9;

    localparam int POS_INDEX = 1;
    localparam int POS_SPEED = 2;

    // folded checksum accumulator: ten 16-bit words, each shifted once more
    localparam int ACC_W = 26;

    localparam int ANGLE_W  = 9;
    localparam int DIST_W   = 14;
    localparam int STR_W    = 16;
    localparam int SPEED_W  = 16;
    localparam int TDATA_W  = 56;
    localparam int TUSER_W  = 2;

    // microcode
    localparam int UC_ADDR_W = 5;
    localparam int STEP_W    = 5;

    typedef enum logic [2:0] {
        LD_NONE,
        LD_LO,
        LD_HI,
        LD_STL,
        LD_STH
    } lpd_ld_t;

    typedef enum logic [1:0] {
        JC_NONE,
        JC_NOTOK,
        JC_ALWAYS
    } lpd_jc_t;

    typedef struct packed {
        logic                 rd;
        logic [UC_ADDR_W-1:0] addr;
        lpd_ld_t              ld;
        logic                 emit;
        logic                 last;
        lpd_jc_t              jc;
        logic [STEP_W-1:0]    tgt;
        logic                 fin;
    } lpd_uword_t;

    // intake -> sequencer hand-over
    typedef struct packed {
        logic               start;
        logic               ok;
        logic [ANGLE_W-1:0] base;
        logic [SPEED_W-1:0] speed;
    } lpd_pkt_t;

    function automatic lpd_uword_t lpd_mk(
        input logic                 rd,
        input logic [UC_ADDR_W-1:0] addr,
        input lpd_ld_t              ld,
        input logic                 emit,
        input logic                 last
    );
        lpd_uword_t w;
        w.rd   = rd;
        w.addr = addr;
        w.ld   = ld;
        w.emit = emit;
        w.last = last;
        w.jc   = JC_NONE;
        w.tgt  = '0;
        w.fin  = 1'b0;
        return w;
    endfunction

    // Program: a checksum gate, then for each reading four reads, a final
    // load and an emit. Reads are registered, so each load trails its read.
    function automatic lpd_uword_t lpd_ucode(input logic [STEP_W-1:0] step);
        lpd_uword_t w;
        w = lpd_mk(1'b0, 5'd0, LD_NONE, 1'b0, 1'b0);
        case (step)
            5'd0:
            begin
                w.jc  = JC_NOTOK;
                w.tgt = 5'd25;
            end
            5'd1:  w = lpd_mk(1'b1, 5'd4,  LD_NONE, 1'b0, 1'b0);
            5'd2:  w = lpd_mk(1'b1, 5'd5,  LD_LO,   1'b0, 1'b0);
            5'd3:  w = lpd_mk(1'b1, 5'd6,  LD_HI,   1'b0, 1'b0);
            5'd4:  w = lpd_mk(1'b1, 5'd7,  LD_STL,  1'b0, 1'b0);
            5'd5:  w = lpd_mk(1'b0, 5'd0,  LD_STH,  1'b0, 1'b0);
            5'd6:  w = lpd_mk(1'b0, 5'd0,  LD_NONE, 1'b1, 1'b0);
            5'd7:  w = lpd_mk(1'b1, 5'd8,  LD_NONE, 1'b0, 1'b0);
            5'd8:  w = lpd_mk(1'b1, 5'd9,  LD_LO,   1'b0, 1'b0);
            5'd9:  w = lpd_mk(1'b1, 5'd10, LD_HI,   1'b0, 1'b0);
            5'd10: w = lpd_mk(1'b1, 5'd11, LD_STL,  1'b0, 1'b0);
            5'd11: w = lpd_mk(1'b0, 5'd0,  LD_STH,  1'b0, 1'b0);
            5'd12: w = lpd_mk(1'b0, 5'd0,  LD_NONE, 1'b1, 1'b0);
            5'd13: w = lpd_mk(1'b1, 5'd12, LD_NONE, 1'b0, 1'b0);
            5'd14: w = lpd_mk(1'b1, 5'd13, LD_LO,   1'b0, 1'b0);
            5'd15: w = lpd_mk(1'b1, 5'd14, LD_HI,   1'b0, 1'b0);
            5'd16: w = lpd_mk(1'b1, 5'd15, LD_STL,  1'b0, 1'b0);
            5'd17: w = lpd_mk(1'b0, 5'd0,  LD_STH,  1'b0, 1'b0);
            5'd18: w = lpd_mk(1'b0, 5'd0,  LD_NONE, 1'b1, 1'b0);
            5'd19: w = lpd_mk(1'b1, 5'd16, LD_NONE, 1'b0, 1'b0);
            5'd20: w = lpd_mk(1'b1, 5'd17, LD_LO,   1'b0, 1'b0);
            5'd21: w = lpd_mk(1'b1, 5'd18, LD_HI,   1'b0, 1'b0);
            5'd22: w = lpd_mk(1'b1, 5'd19, LD_STL,  1'b0, 1'b0);
            5'd23: w = lpd_mk(1'b0, 5'd0,  LD_STH,  1'b0, 1'b0);
            5'd24: w = lpd_mk(1'b0, 5'd0,  LD_NONE, 1'b1, 1'b1);
            default:
            begin
                w.jc  = JC_ALWAYS;
                w.tgt = 5'd0;
                w.fin = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/lpd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 22
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lpd_intake.sv =====
// ----------------------------------------------------------------------------
// Lidar packet intake
// Start-byte hunt, byte count, running checksum and header capture.
// ----------------------------------------------------------------------------
module lpd_intake #(
    parameter int PACKET_BYTES = lpd_pkg::PACKET_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic [7:0]                        rx_byte,
    output logic                              we,
    output logic [$clog2(PACKET_BYTES)-1:0]   waddr,
    output lpd_pkg::lpd_pkt_t                 pkt
);
    import lpd_pkg::*;

    localparam int CNT_W     = $clog2(PACKET_BYTES + 1);
    localparam int ADDR_W    = $clog2(PACKET_BYTES);
    localparam int POS_CHECK = PACKET_BYTES - 2;

    logic               hunting_reg, hunting_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [7:0]         wlo_reg, wlo_next;
    logic [7:0]         chk_lo_reg, chk_lo_next;
    logic [ANGLE_W-1:0] base_reg, base_next;
    logic               idx_ok_reg, idx_ok_next;
    logic [SPEED_W-1:0] speed_reg, speed_next;

    logic [CNT_W-1:0]   count_inc;
    logic [7:0]         idx_off;
    logic [15:0]        fold;
    logic               ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            count_reg   <= '0;
        end
        else
        begin
            hunting_reg <= hunting_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        wlo_reg    <= wlo_next;
        chk_lo_reg <= chk_lo_next;
        base_reg   <= base_next;
        idx_ok_reg <= idx_ok_next;
        speed_reg  <= speed_next;
    end

    // end-around fold of the accumulator to 15 bits
    assign fold = 16'({1'b0, acc_reg[14:0]}) + 16'(acc_reg[ACC_W-1:15]);
    assign ok   = ({1'b0, fold[14:0]} == {rx_byte, chk_lo_reg}) && idx_ok_reg;

    always_comb
    begin
        hunting_next = hunting_reg;
        count_next   = count_reg;
        acc_next     = acc_reg;
        wlo_next     = wlo_reg;
        chk_lo_next  = chk_lo_reg;
        base_next    = base_reg;
        idx_ok_next  = idx_ok_reg;
        speed_next   = speed_reg;
        count_inc    = count_reg + 1'b1;
        idx_off      = rx_byte - INDEX_FIRST;
        we           = 1'b0;
        waddr        = count_reg[ADDR_W-1:0];
        pkt.start    = 1'b0;
        pkt.ok       = ok;
        pkt.base     = base_reg;
        pkt.speed    = speed_reg;

        if (accept)
        begin
            if (hunting_reg)
            begin
                if (rx_byte == START_BYTE)
                begin
                    we           = 1'b1;
                    waddr        = '0;
                    hunting_next = 1'b0;
                    count_next   = CNT_W'(1);
                    acc_next     = '0;
                    wlo_next     = rx_byte;
                end
            end
            else
            begin
                we         = (count_reg < CNT_W'(PACKET_BYTES));
                count_next = count_inc;
                if (count_reg == CNT_W'(POS_INDEX))
                begin
                    base_next   = {idx_off[ANGLE_W-3:0], 2'b00};
                    idx_ok_next = (rx_byte >= INDEX_FIRST) && (rx_byte <= INDEX_LAST);
                end
                if (count_reg == CNT_W'(POS_SPEED))
                begin
                    speed_next[7:0] = rx_byte;
                end
                if (count_reg == CNT_W'(POS_SPEED + 1))
                begin
                    speed_next[15:8] = rx_byte;
                end
                if (count_reg < CNT_W'(POS_CHECK))
                begin
                    if (!count_reg[0])
                    begin
                        wlo_next = rx_byte;
                    end
                    else
                    begin
                        acc_next = (acc_reg << 1) + ACC_W'({rx_byte, wlo_reg});
                    end
                end
                if (count_reg == CNT_W'(POS_CHECK))
                begin
                    chk_lo_next = rx_byte;
                end
                if (count_inc >= CNT_W'(PACKET_BYTES))
                begin
                    count_next   = '0;
                    hunting_next = 1'b1;
                    pkt.start    = 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/lpd_sequencer.sv =====
// ----------------------------------------------------------------------------
// Lidar packet readout sequencer
// Microcoded readout of the four readings into the output register.
// ----------------------------------------------------------------------------
module lpd_sequencer #(
    parameter int PACKET_BYTES = lpd_pkg::PACKET_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lpd_pkg::lpd_pkt_t               pkt,
    output logic                            busy,
    output logic                            rd_en,
    output logic [$clog2(PACKET_BYTES)-1:0] rd_addr,
    input  logic [7:0]                      rd_data,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lpd_pkg::TDATA_W-1:0]     m_tdata,
    output logic [lpd_pkg::TUSER_W-1:0]     m_tuser,
    output logic                            m_tlast
);
    import lpd_pkg::*;

    localparam int ADDR_W = $clog2(PACKET_BYTES);

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              ok_reg, ok_next;
    logic [1:0]        k_reg, k_next;
    logic [7:0]        lo_reg, hi_reg, stl_reg, sth_reg;
    logic              valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic [TUSER_W-1:0] user_reg, user_next;
    logic              last_reg, last_next;

    lpd_uword_t         uw;
    logic               slot_free;
    logic               load;
    logic               jump;
    logic               bad;
    logic [ANGLE_W-1:0] angle;
    logic [DIST_W-1:0]  distance;
    logic [STR_W-1:0]   strength;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        k_reg    <= k_next;
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
        if (busy_reg)
        begin
            case (uw.ld)
                LD_LO:   lo_reg  <= rd_data;
                LD_HI:   hi_reg  <= rd_data;
                LD_STL:  stl_reg <= rd_data;
                LD_STH:  sth_reg <= rd_data;
                default: ;
            endcase
        end
    end

    assign uw        = lpd_ucode(step_reg);
    assign slot_free = !valid_reg || m_tready;

    // reading datapath
    assign bad      = hi_reg[7] | hi_reg[6];
    assign angle    = pkt.base + ANGLE_W'(k_reg);
    assign distance = bad ? '0 : {hi_reg[5:0], lo_reg};
    assign strength = bad ? '0 : {sth_reg, stl_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        step_next  = step_reg;
        ok_next    = ok_reg;
        k_next     = k_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        rd_en      = 1'b0;
        load       = 1'b0;
        jump       = 1'b0;

        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end

        if (busy_reg)
        begin
            rd_en = uw.rd;
            jump  = (uw.jc == JC_ALWAYS) || ((uw.jc == JC_NOTOK) && !ok_reg);
            if (uw.emit)
            begin
                load = slot_free;
            end
            if (jump)
            begin
                step_next = uw.tgt;
            end
            else if (!uw.emit || slot_free)
            begin
                step_next = step_reg + 1'b1;
            end
            if (uw.fin)
            begin
                busy_next = 1'b0;
            end
        end

        if (load)
        begin
            valid_next = 1'b1;
            data_next  = TDATA_W'({pkt.speed, strength, distance, angle});
            user_next  = {hi_reg[6], hi_reg[7]};
            last_next  = uw.last;
            k_next     = k_reg + 1'b1;
        end

        if (pkt.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            ok_next   = pkt.ok;
            k_next    = '0;
        end
    end

    assign busy     = busy_reg;
    assign rd_addr  = uw.addr[ADDR_W-1:0];
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hw/rtl/lidar_packet_decoder.sv =====
// ----------------------------------------------------------------------------
// Lidar packet decoder
// Decodes the 22-byte serial packets of a rotating distance sensor into
// four readings per valid packet.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata[7:0] rx_byte
//  m_      | out | m_tvalid/m_tready  | tdata: angle, distance_mm, strength,
//          |     |                    | speed_q6; tuser: flags; tlast
//
//  Cycles: one byte transaction per cycle while a packet is being gathered.
//  After the final byte the readout microprogram runs: four readings at six
//  steps each, plus gate and end steps, for a valid packet; only the gate
//  and end steps for a rejected one; s_tready is low while it runs.
//  Output back-pressure holds the program on its emit steps only.
//  Reset (rst_n, asynchronous, active low) starts the decoder hunting for
//  the start byte with the output empty.
// ----------------------------------------------------------------------------
module lidar_packet_decoder #(
    parameter int PACKET_BYTES = lpd_pkg::PACKET_BYTES
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [8:0] angle, [22:9] distance_mm, [38:23] strength, [54:39] speed_q6,
    // [55] zero fill
    output logic [lpd_pkg::TDATA_W-1:0] m_tdata,
    output logic [lpd_pkg::TUSER_W-1:0] m_tuser,   // [0] invalid_flag, [1] weak_flag
    output logic                        m_tlast    // last_reading
);
    import lpd_pkg::*;

    localparam int ADDR_W = $clog2(PACKET_BYTES);

    logic              accept;
    logic              busy;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;
    lpd_pkt_t          pkt;

    // intake stalls only while the readout program owns the packet store
    assign s_tready = !busy;
    assign accept   = s_tvalid && s_tready;

    lpd_intake #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_intake (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (s_tdata),
        .we      (we),
        .waddr   (waddr),
        .pkt     (pkt)
    );

    // packet store: bytes land at their packet position
    lpd_ram #(
        .WIDTH (8),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (s_tdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    lpd_sequencer #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .pkt      (pkt),
        .busy     (busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/lpd_checker.sv =====
// ----------------------------------------------------------------------------
// Lidar packet decoder checker
// Port-level checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "lidar_packet_decoder_assert.svh"

module lpd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lpd_pkg::TDATA_W-1:0] m_tdata,
    input logic [lpd_pkg::TUSER_W-1:0] m_tuser,
    input logic                        m_tlast
);

    // a held reading keeps its payload
    `LPD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled reading changed")

    // mid-packet readings mean the readout program still runs
    `LPD_ASSERT_NOW(a_busy_mid, m_tvalid && !m_tlast, !s_tready,
        "input taken while a packet is being read out")

    `LPD_ASSERT_NOW(a_angle_range, m_tvalid, m_tdata[8:0] <= 9'd359,
        "angle out of range")

    // a flagged reading carries no distance or strength
    `LPD_ASSERT_NOW(a_flag_zero, m_tvalid && (m_tuser != 2'b00), m_tdata[38:9] == 30'd0,
        "flagged reading with non-zero measurement")

endmodule

bind lidar_packet_decoder lpd_checker u_lpd_checker (.*);
